/* rtl/per_process_burst_trip_table_unit_macros.svh */
// Assertion macros shared by the burst trip table RTL.
// No dependencies; included by the modules that carry checks.
`ifndef PER_PROCESS_BURST_TRIP_TABLE_UNIT_MACROS_SVH
`define PER_PROCESS_BURST_TRIP_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ppbt_pkg.sv */
// Shared types and constants of the burst trip table.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ppbt_pkg;

    localparam int PPBT_PID_BITS  = 15;
    localparam int PPBT_SUM_WIDTH = 32;

    localparam int OPCODE_W  = 2;
    localparam int PID_W     = 15;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EXEMPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PID = 2'd2;

    localparam logic              ENABLE_RST  = 1'b1;
    localparam logic [DATA_W-1:0] CEILING_RST = 32'd983040;
    localparam logic [PID_W-1:0]  OWN_PID_RST = '0;

    localparam logic [DATA_W-1:0] OUT_MAX = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;    // write a zero entry at the sweep counter
        logic load;   // capture the item and read its entry
        logic exec;   // update the entry and register the result
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

/* rtl/ppbt_ctrl.sv */
// Controller state machine of the burst trip table: clearing sweep, idle, execute.
// Depends on ppbt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "per_process_burst_trip_table_unit_macros.svh"

module ppbt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ppbt_pkg::t_dp_sts  i_sts,
    output ppbt_pkg::t_ctl_cmd o_cmd,
    output logic               o_busy
);
    import ppbt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.clr  = (r_state == ST_CLEAR);
    assign o_cmd.load = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_busy     = (r_state != ST_IDLE);

    `PPBT_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, o_cmd.load, r_state == ST_EXEC,
        "accepted item did not enter execute")
    `PPBT_ASSERT_NEXT(a_exec_once, i_clk, i_rst_n, o_cmd.exec, r_state == ST_IDLE,
        "execute did not return to idle")
    `PPBT_ASSERT_NEXT(a_clear_holds, i_clk, i_rst_n, o_cmd.clr && !i_sts.clr_last,
        o_busy && o_cmd.clr, "clearing sweep ended early")

endmodule

/* rtl/ppbt_datapath.sv */
// Datapath of the burst trip table: configuration registers, entry memory,
// saturating window sum, trip decision and result registers. Depends on ppbt_pkg.
`timescale 1ns / 1ps
`include "per_process_burst_trip_table_unit_macros.svh"

module ppbt_datapath #(
    parameter int PID_BITS  = ppbt_pkg::PPBT_PID_BITS,
    parameter int SUM_WIDTH = ppbt_pkg::PPBT_SUM_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppbt_pkg::t_ctl_cmd                i_cmd,
    output ppbt_pkg::t_dp_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [ppbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppbt_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic [ppbt_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [ppbt_pkg::PID_W-1:0]        i_process_id,
    input  logic [ppbt_pkg::DATA_W-1:0]       i_weight,
    input  logic [ppbt_pkg::DATA_W-1:0]       i_epoch,
    output logic                              o_done,
    output logic                              o_tripped,
    output logic                              o_blocked,
    output logic [ppbt_pkg::DATA_W-1:0]       o_window_sum
);
    import ppbt_pkg::*;

    localparam int DEPTH = 1 << PID_BITS;
    localparam int WIDE  = ((SUM_WIDTH > DATA_W) ? SUM_WIDTH : DATA_W) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic                 valid;
        logic                 blocked;
        logic                 exempt;
        logic [DATA_W-1:0]    epoch;
        logic [SUM_WIDTH-1:0] sum;
    } t_entry;

    // Configuration registers.
    logic              r_enable;
    logic [DATA_W-1:0] r_ceiling;
    logic [PID_W-1:0]  r_own_pid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= ENABLE_RST;
            r_ceiling <= CEILING_RST;
            r_own_pid <= OWN_PID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                CFG_CEILING: r_ceiling <= i_cfg_data;
                CFG_OWN_PID: r_own_pid <= i_cfg_data[PID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing sweep counter.
    logic [PID_BITS-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_sts.clr_last = &r_clr_cnt;

    // Captured item.
    logic [OPCODE_W-1:0] r_op;
    logic [PID_W-1:0]    r_pid;
    logic [PID_BITS-1:0] r_ix;
    logic [DATA_W-1:0]   r_weight;
    logic [DATA_W-1:0]   r_epoch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_pid    <= i_process_id;
            r_ix     <= PID_BITS'(i_process_id);
            r_weight <= i_weight;
            r_epoch  <= i_epoch;
        end
    end

    // Entry memory: one write port, one registered read port.
    t_entry              mem [0:DEPTH-1];
    t_entry              r_rd;
    logic                mem_we;
    logic [PID_BITS-1:0] mem_wa;
    t_entry              mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.load) begin
            r_rd <= mem[PID_BITS'(i_process_id)];
        end
    end

    // Read-modify-write of the entry.
    logic                 own;
    logic                 skip;
    logic                 is_add;
    logic                 upd;
    logic [SUM_WIDTH-1:0] base_sum;
    logic [WIDE-1:0]      wide_sum;
    logic [SUM_WIDTH-1:0] new_sum;
    logic                 trip;
    logic [SUM_WIDTH-1:0] sum_after;
    logic [WIDE-1:0]      sum_wide_out;
    t_entry               upd_entry;

    always_comb begin
        own      = (r_pid == r_own_pid);
        is_add   = (r_op == OP_ADD);
        skip     = !r_enable || (r_weight == '0) || (r_pid <= PID_W'(1)) || own
                   || r_rd.exempt;
        upd      = is_add && !skip;
        // A new entry or an epoch change starts the window from zero.
        base_sum = (r_rd.valid && (r_rd.epoch == r_epoch)) ? r_rd.sum : '0;
        wide_sum = WIDE'(base_sum) + WIDE'(r_weight);
        new_sum  = (wide_sum > WIDE'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_WIDTH-1:0];
        trip     = upd && (WIDE'(new_sum) >= WIDE'(r_ceiling)) && !r_rd.blocked;

        upd_entry = r_rd;
        if (upd) begin
            upd_entry.valid   = 1'b1;
            upd_entry.blocked = r_rd.blocked | trip;
            upd_entry.epoch   = r_epoch;
            upd_entry.sum     = new_sum;
        end
        if (r_op == OP_EXEMPT) begin
            upd_entry.exempt = 1'b1;
        end

        if (upd) begin
            sum_after = new_sum;
        end else if (r_rd.valid) begin
            sum_after = r_rd.sum;
        end else begin
            sum_after = '0;
        end
        sum_wide_out = WIDE'(sum_after);

        if (i_cmd.clr) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt;
            mem_wd = '0;
        end else begin
            mem_we = i_cmd.exec && (upd || (r_op == OP_EXEMPT));
            mem_wa = r_ix;
            mem_wd = upd_entry;
        end
    end

    // Result registers.
    logic              r_done;
    logic              r_tripped;
    logic              r_blocked;
    logic [DATA_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_tripped <= trip;
            r_blocked <= !own && (r_rd.blocked | trip);
            r_sum     <= (sum_wide_out > WIDE'(OUT_MAX)) ? OUT_MAX
                                                        : sum_wide_out[DATA_W-1:0];
        end
    end

    assign o_done       = r_done;
    assign o_tripped    = r_tripped;
    assign o_blocked    = r_blocked;
    assign o_window_sum = r_sum;

    `PPBT_ASSERT_NEXT(a_exec_strobe, i_clk, i_rst_n, i_cmd.exec, r_done,
        "execute did not produce a result beat")
    `PPBT_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, r_done, !r_done,
        "result strobe lasted more than one cycle")
    `PPBT_ASSERT_SAME(a_trip_blocks, i_clk, i_rst_n, r_done && r_tripped, r_blocked,
        "trip reported without the process reading blocked")

endmodule

/* rtl/per_process_burst_trip_table_unit.sv */
// Top level of the per-process burst trip table: controller plus datapath.
// Depends on ppbt_pkg, ppbt_ctrl and ppbt_datapath.
//
// Usage:
//   Items enter on start when busy is low: opcode, process id, weight, epoch.
//   Each item gives exactly one result beat: o_done is high for one cycle with
//   o_tripped, o_blocked and o_window_sum. The receiver cannot hold results off.
//   The cycle after the accepting edge is the execute cycle, and the result
//   beat shows in the cycle after that. Busy is high in the execute cycle, when
//   the table entry read at acceptance is updated and written back through the
//   entry memory, so a new item waits until that cycle ends.
//   A new item may be accepted during the cycle its predecessor's result shows.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is
//   always high. Index 0 enable, 1 ceiling, 2 own process id; others ignored.
//   Reset: synchronous, active low. After reset the block sweeps the entry
//   memory to clear the valid, blocked and exempt bits, one entry per cycle,
//   over all 2**PID_BITS entries (32768 with the default), with busy high throughout.
`timescale 1ns / 1ps

module per_process_burst_trip_table_unit #(
    parameter int PID_BITS  = ppbt_pkg::PPBT_PID_BITS,
    parameter int SUM_WIDTH = ppbt_pkg::PPBT_SUM_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ppbt_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [ppbt_pkg::PID_W-1:0]     i_process_id,
    input  logic [ppbt_pkg::DATA_W-1:0]    i_weight,
    input  logic [ppbt_pkg::DATA_W-1:0]    i_epoch,
    output logic                           o_done,
    output logic                           o_tripped,
    output logic                           o_blocked,
    output logic [ppbt_pkg::DATA_W-1:0]    o_window_sum,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppbt_pkg::DATA_W-1:0]    i_cfg_data
);
    import ppbt_pkg::*;

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    assign o_cfg_ready = 1'b1;

    ppbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ppbt_datapath #(
        .PID_BITS  (PID_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_opcode),
        .i_process_id (i_process_id),
        .i_weight     (i_weight),
        .i_epoch      (i_epoch),
        .o_done       (o_done),
        .o_tripped    (o_tripped),
        .o_blocked    (o_blocked),
        .o_window_sum (o_window_sum)
    );

endmodule

/* tb/sv/per_process_burst_trip_table_unit_tb.sv */
// Self-checking testbench for the per-process burst trip table.
// Depends on ppbt_pkg and per_process_burst_trip_table_unit; drives items, writes
// registers between phases and checks every result beat against a local table model.
`timescale 1ns / 1ps

module per_process_burst_trip_table_unit_tb;

    import ppbt_pkg::*;

    localparam int TBL_DEPTH   = 1 << PPBT_PID_BITS;
    localparam int STALL_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PID_W-1:0]    pid;
        logic [DATA_W-1:0]   weight;
        logic [DATA_W-1:0]   epoch;
    } t_trip_item;

    typedef struct packed {
        logic              tripped;
        logic              blocked;
        logic [DATA_W-1:0] window_sum;
    } t_trip_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [OPCODE_W-1:0]  i_opcode     = '0;
    logic [PID_W-1:0]     i_process_id = '0;
    logic [DATA_W-1:0]    i_weight     = '0;
    logic [DATA_W-1:0]    i_epoch      = '0;
    logic                 o_done;
    logic                 o_tripped;
    logic                 o_blocked;
    logic [DATA_W-1:0]    o_window_sum;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [DATA_W-1:0]    i_cfg_data   = '0;

    per_process_burst_trip_table_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_process_id (i_process_id),
        .i_weight     (i_weight),
        .i_epoch      (i_epoch),
        .o_done       (o_done),
        .o_tripped    (o_tripped),
        .o_blocked    (o_blocked),
        .o_window_sum (o_window_sum),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the process table and the registers.
    bit [DATA_W-1:0] tbl_sum     [0:TBL_DEPTH-1];
    bit [DATA_W-1:0] tbl_epoch   [0:TBL_DEPTH-1];
    bit              tbl_valid   [0:TBL_DEPTH-1];
    bit              tbl_blocked [0:TBL_DEPTH-1];
    bit              tbl_exempt  [0:TBL_DEPTH-1];

    logic              cfg_enable  = ENABLE_RST;
    logic [DATA_W-1:0] cfg_ceiling = CEILING_RST;
    logic [PID_W-1:0]  cfg_own_pid = OWN_PID_RST;

    t_trip_item   pending_q [$];
    t_trip_result trip_expect_q [$];
    t_trip_item   cur_item;
    bit           no_gaps = 1'b0;
    int           err_count = 0;
    int           stall_cycles = 0;

    logic [PID_W-1:0]  pool_base;
    logic [DATA_W-1:0] epoch_base;

    function automatic t_trip_result predict_trip(input t_trip_item it);
        t_trip_result      res;
        logic [PID_W-1:0]  ix;
        logic              own;
        logic              skip;
        logic [DATA_W:0]   acc;
        logic [DATA_W-1:0] s;
        ix  = it.pid;
        own = (it.pid == cfg_own_pid);
        res = '0;
        if (it.opcode == OP_ADD) begin
            skip = !cfg_enable || (it.weight == '0) || (it.pid <= 1) || own || tbl_exempt[ix];
            if (!skip) begin
                s = (tbl_valid[ix] && tbl_epoch[ix] == it.epoch) ? tbl_sum[ix] : '0;
                acc = {1'b0, s} + {1'b0, it.weight};
                s = acc[DATA_W] ? OUT_MAX : acc[DATA_W-1:0];
                tbl_sum[ix]   = s;
                tbl_epoch[ix] = it.epoch;
                tbl_valid[ix] = 1'b1;
                if (s >= cfg_ceiling && !tbl_blocked[ix]) begin
                    tbl_blocked[ix] = 1'b1;
                    res.tripped = 1'b1;
                end
            end
        end else if (it.opcode == OP_EXEMPT) begin
            tbl_exempt[ix] = 1'b1;
        end
        // Opcode 3 falls through as a plain query.
        res.blocked    = !own && tbl_blocked[ix];
        res.window_sum = tbl_valid[ix] ? tbl_sum[ix] : '0;
        return res;
    endfunction

    // Driver: presents queued items and predicts each one as its beat is accepted.
    always @(posedge i_clk) begin : drive_items
        logic next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                trip_expect_q.push_back(predict_trip(cur_item));
                next_start = 1'b0;
            end
            if (!next_start && pending_q.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
                cur_item     = pending_q.pop_front();
                i_opcode     <= cur_item.opcode;
                i_process_id <= cur_item.pid;
                i_weight     <= cur_item.weight;
                i_epoch      <= cur_item.epoch;
                next_start   = 1'b1;
            end
            start <= next_start;
        end
    end

    task automatic check_field(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
            err_count++;
        end
    endtask

    // Monitor: every result beat lasts one cycle and is taken at the edge that ends it.
    always @(posedge i_clk) begin : watch_results
        t_trip_result exp_r;
        if (i_rst_n && o_done) begin
            if (trip_expect_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none actual %0h/%0h/%0h",
                         $time, o_tripped, o_blocked, o_window_sum);
                err_count++;
            end else begin
                exp_r = trip_expect_q.pop_front();
                check_field("tripped", DATA_W'(exp_r.tripped), DATA_W'(o_tripped));
                check_field("blocked", DATA_W'(exp_r.blocked), DATA_W'(o_blocked));
                check_field("window_sum", exp_r.window_sum, o_window_sum);
            end
        end
    end

    // Watchdog: the clearing sweep after reset is the longest legal quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("per_process_burst_trip_table_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [PID_W-1:0] pid,
                             input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] ep);
        t_trip_item it;
        it.opcode = op;
        it.pid    = pid;
        it.weight = w;
        it.epoch  = ep;
        pending_q.push_back(it);
    endtask

    // Sampled at the falling edge so that all rising-edge updates have settled.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || start || busy || trip_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:  cfg_enable  = data[0];
            CFG_CEILING: cfg_ceiling = data;
            CFG_OWN_PID: cfg_own_pid = data[PID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic en, input logic [DATA_W-1:0] ceil,
                            input logic [PID_W-1:0] own);
        wait_drained();
        write_reg(CFG_ENABLE, {31'd0, en});
        write_reg(CFG_CEILING, ceil);
        write_reg(CFG_OWN_PID, {17'd0, own});
    endtask

    // Mostly bursts of adds on a small pool of processes within one epoch, so that
    // windows fill up and trip; the rest hits reserved ids, odd opcodes and wide values.
    task automatic queue_random(input int count);
        logic [OPCODE_W-1:0] op;
        logic [PID_W-1:0]    pid;
        logic [DATA_W-1:0]   w;
        logic [DATA_W-1:0]   ep;
        logic [DATA_W-1:0]   wmax;
        int                  r;
        wmax = (cfg_ceiling < 3) ? 32'd3 : cfg_ceiling / 3;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 75)      op = OP_ADD;
            else if (r < 93) op = OP_QUERY;
            else if (r < 97) op = 2'd3;
            else             op = OP_EXEMPT;

            r = $urandom_range(99);
            if (r < 5)       pid = PID_W'($urandom_range(1));
            else if (r < 8)  pid = cfg_own_pid;
            else if (r < 20) pid = PID_W'($urandom_range(TBL_DEPTH - 1));
            else             pid = pool_base + PID_W'($urandom_range(63));

            r = $urandom_range(99);
            if (r < 5)       w = '0;
            else if (r < 10) w = OUT_MAX;
            else if (r < 20) w = $urandom;
            else             w = $urandom_range(wmax, 1);

            if ($urandom_range(99) < 3)
                epoch_base = epoch_base + 1;
            ep = ($urandom_range(99) < 10) ? $urandom : epoch_base;
            push_item(op, pid, w, ep);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings.
        push_item(OP_QUERY, 15'd5, '0, '0);
        push_item(OP_ADD, 15'd0, 32'd100, 32'd7);
        push_item(OP_ADD, 15'd1, 32'd100, 32'd7);
        push_item(OP_ADD, 15'd5, 32'd0, 32'd7);
        push_item(OP_ADD, 15'd5, 32'd500000, 32'd7);
        push_item(OP_ADD, 15'd5, 32'd483040, 32'd7);
        push_item(OP_ADD, 15'd5, 32'd1, 32'd7);
        push_item(OP_ADD, 15'd5, 32'd10, 32'd8);
        push_item(OP_ADD, 15'h7FFF, OUT_MAX, OUT_MAX);
        push_item(OP_ADD, 15'h7FFF, OUT_MAX, OUT_MAX);
        push_item(OP_EXEMPT, 15'h7FFF, '0, '0);
        push_item(OP_ADD, 15'h7FFF, 32'd5, OUT_MAX);
        push_item(2'd3, 15'd5, OUT_MAX, OUT_MAX);
        push_item(OP_QUERY, 15'd5, '0, '0);
        push_item(OP_ADD, 15'd2, 32'h8000_0000, 32'd0);
        push_item(OP_EXEMPT, 15'd3, '0, '0);
        push_item(OP_ADD, 15'd3, 32'd2000000, 32'd0);
        push_item(OP_QUERY, 15'd3, '0, '0);

        // Own id reads as never blocked and is never charged.
        set_regs(1'b1, CEILING_RST, 15'd5);
        push_item(OP_QUERY, 15'd5, '0, '0);
        push_item(OP_ADD, 15'd5, 32'd77, 32'd8);
        // Accounting disabled.
        set_regs(1'b0, CEILING_RST, 15'h7FFF);
        push_item(OP_ADD, 15'd6, 32'd1234, 32'd1);
        push_item(OP_QUERY, 15'h7FFF, '0, '0);
        // Zero ceiling trips on the first charge, a full ceiling only on saturation.
        set_regs(1'b1, 32'd0, 15'h7FFF);
        push_item(OP_ADD, 15'd9, 32'd1, 32'd1);
        set_regs(1'b1, OUT_MAX, 15'd0);
        push_item(OP_ADD, 15'd10, 32'hFFFF_FFFE, 32'd3);
        push_item(OP_ADD, 15'd10, 32'd1, 32'd3);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(1'b1, $urandom_range(200000, 2000), PID_W'($urandom_range(32767, 2)));
                1: set_regs(1'b0, $urandom, PID_W'($urandom));
                2: set_regs(1'b1, 32'd0, 15'd0);
                3: set_regs(1'b1, OUT_MAX, 15'h7FFF);
                4: set_regs(1'b1, $urandom_range(50, 1), 15'd1);
                default: set_regs(1'b1, $urandom, PID_W'($urandom));
            endcase
            pool_base  = PID_W'($urandom);
            epoch_base = $urandom;
            no_gaps    = (ph == 2);
            if (ph == 3) begin
                // The sender holds off mid-phase until every result is back.
                queue_random(165);
                wait_drained();
                queue_random(165);
            end else begin
                queue_random(330);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && trip_expect_q.size() == 0)
            $display("per_process_burst_trip_table_unit_tb: done, clean");
        else
            $display("per_process_burst_trip_table_unit_tb: done, errors");
        $finish;
    end

endmodule
